FILE: sv/slr_pkg.sv
// Shared types, constants and arithmetic for the subtractive lagged generator.
package slr_pkg;

    localparam int TBL_LEN      = 55;
    localparam int SCATTER      = 21;
    localparam int TRAIL_TAP    = 31;
    localparam int SCATTER_WR   = TBL_LEN - SCATTER;
    localparam int MIX_PASSES   = 4;
    localparam int MIX_STEPS    = MIX_PASSES * TBL_LEN;
    localparam int WORD_W       = 30;
    localparam int SEED_W       = 28;
    localparam int COUNT_W      = 32;
    localparam int STEP_W       = 8;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [SEED_W-1:0]  t_seed;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [STEP_W-1:0]  t_step;

    localparam t_word MODV      = 30'd1000000000;
    localparam t_seed SEED_BASE = 28'd161803398;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_NEAR,
        CELL_FAR
    } t_cell_sel;

    typedef enum logic [1:0] {
        RING_HOLD,
        RING_STEP,
        RING_SCATTER,
        RING_MIX
    } t_ring_op;

    typedef struct packed {
        t_ring_op op;
        t_word    data;
    } t_ring_ctl;

    function automatic t_word sub_mod(input t_word a, input t_word b);
        logic [WORD_W:0] wide;
        wide = {1'b0, a} + {1'b0, MODV} - {1'b0, b};
        return (a >= b) ? (a - b) : wide[WORD_W-1:0];
    endfunction

    function automatic t_word seed_word(input t_seed seed);
        t_seed diff;
        diff = SEED_BASE - seed;
        return (seed > SEED_BASE) ? '0 : {{(WORD_W-SEED_W){1'b0}}, diff};
    endfunction

endpackage

FILE: sv/slr_in_if.sv
// Request channel: command and seed with a valid/ready handshake.
interface slr_in_if;
    import slr_pkg::*;

    logic  valid;
    logic  ready;
    logic  command;
    t_seed seed;

    modport source (output valid, output command, output seed, input ready);
    modport sink   (input valid, input command, input seed, output ready);
endinterface

FILE: sv/slr_out_if.sv
// Result channel: deviate and draw count with a valid/ready handshake.
interface slr_out_if;
    import slr_pkg::*;

    logic   valid;
    logic   ready;
    t_word  deviate;
    t_count draw_count;

    modport source (output valid, output deviate, output draw_count, input ready);
    modport sink   (input valid, input deviate, input draw_count, output ready);
endinterface

FILE: sv/slr_cell.sv
// One table word of the ring, fed by its near and far neighbors.
module slr_cell
    import slr_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_sel i_sel,
    input  t_word     i_near,
    input  t_word     i_far,
    input  logic      i_wr_en,
    input  t_word     i_wr_data,
    output t_word     o_word
);

    t_word r_word;
    t_word n_word;

    always_comb begin
        unique case (i_sel)
            CELL_NEAR: n_word = i_near;
            CELL_FAR:  n_word = i_far;
            default:   n_word = r_word;
        endcase
        if (i_wr_en) begin
            n_word = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: sv/slr_ring.sv
// Ring of table cells with the lag difference taken at two fixed taps.
module slr_ring
    import slr_pkg::*;
(
    input  logic      i_clk,
    input  t_ring_ctl i_ctl,
    output t_word     o_diff
);

    t_word     w_word [TBL_LEN];
    t_cell_sel w_sel;
    t_word     w_diff;

    always_comb begin
        unique case (i_ctl.op) inside
            RING_STEP, RING_MIX: w_sel = CELL_NEAR;
            RING_SCATTER:        w_sel = CELL_FAR;
            default:             w_sel = CELL_HOLD;
        endcase
    end

    assign w_diff = sub_mod(w_word[0], w_word[TRAIL_TAP]);
    assign o_diff = w_diff;

    for (genvar j = 0; j < TBL_LEN; j++) begin : g_cell
        localparam int NEAR = (j + 1) % TBL_LEN;
        localparam int FAR  = (j + SCATTER) % TBL_LEN;

        logic  w_wr_en;
        t_word w_wr_data;

        if (j == SCATTER_WR) begin : g_scatter_port
            assign w_wr_en   = (i_ctl.op == RING_SCATTER);
            assign w_wr_data = i_ctl.data;
        end else if (j == TBL_LEN - 1) begin : g_mix_port
            assign w_wr_en   = (i_ctl.op == RING_MIX);
            assign w_wr_data = w_diff;
        end else begin : g_no_port
            assign w_wr_en   = 1'b0;
            assign w_wr_data = w_diff;
        end

        slr_cell u_cell (
            .i_clk     (i_clk),
            .i_sel     (w_sel),
            .i_near    (w_word[NEAR]),
            .i_far     (w_word[FAR]),
            .i_wr_en   (w_wr_en),
            .i_wr_data (w_wr_data),
            .o_word    (w_word[j])
        );
    end

endmodule

FILE: sv/subtractive_lagged_rng.sv
// Top level of the subtractive lagged generator with its sequencer and result queue.
//
// Usage: items arrive on i_in (command, seed) and leave on o_out (deviate,
// draw_count), both with valid/ready handshakes. Every accepted item yields
// exactly one result item.
// A draw is worked out in the cycle it is accepted and its result enters the
// result queue in the next cycle, so draws run at one item per cycle while o_out
// is taken. A reseed, and the first draw after reset, rebuild the 55-word table
// in a row of cells: a scatter phase, an alignment step and the mixing passes,
// then the draw, which pushes its result into the queue.
// The mixing passes are set by the single subtractor between cells 0 and 31.
// Reset clears the sequencer, the queue, the draw count and the seeded flag;
// the table itself is not cleared and is always rebuilt before its first use.
// A two-entry result queue lets one item be accepted while an earlier result
// waits; while both entries are full, or while the table is rebuilt, i_in is
// held not ready. A stalled result holds its value on o_out.
module subtractive_lagged_rng
    import slr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    slr_in_if.sink      i_in,
    slr_out_if.source   o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCATTER,
        S_ALIGN,
        S_MIX,
        S_DRAW
    } t_state;

    t_state    r_state;
    t_step     r_step;
    logic      r_seeded;
    t_word     r_mj;
    t_word     r_mk;
    t_count    r_count;
    logic      r_head_valid;
    t_word     r_head_dev;
    t_count    r_head_cnt;
    logic      r_tail_valid;
    t_word     r_tail_dev;
    t_count    r_tail_cnt;

    t_ring_ctl w_ctl;
    t_word     w_diff;
    logic      w_accept;
    logic      w_reseed;
    logic      w_push;
    logic      w_pop;
    t_word     w_push_dev;
    t_count    w_push_cnt;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_reseed = i_in.command || !r_seeded;
    assign w_push   = (r_state == S_IDLE && w_accept && !w_reseed) || (r_state == S_DRAW);
    assign w_pop    = r_head_valid && o_out.ready;

    assign w_push_dev = (w_diff == '0) ? t_word'(1) : w_diff;
    assign w_push_cnt = (r_state == S_DRAW) ? t_count'(1) : r_count + t_count'(1);

    assign i_in.ready       = (r_state == S_IDLE) && !r_tail_valid;
    assign o_out.valid      = r_head_valid;
    assign o_out.deviate    = r_head_dev;
    assign o_out.draw_count = r_head_cnt;

    always_comb begin
        w_ctl.op   = RING_HOLD;
        w_ctl.data = r_mk;
        unique case (r_state) inside
            S_IDLE: begin
                if (w_accept && !w_reseed) begin
                    w_ctl.op = RING_MIX;
                end
            end
            S_SCATTER: begin
                w_ctl.op   = RING_SCATTER;
                w_ctl.data = (r_step == '0) ? r_mj : r_mk;
            end
            S_ALIGN: w_ctl.op = RING_STEP;
            S_MIX, S_DRAW: w_ctl.op = RING_MIX;
            default: w_ctl.op = RING_HOLD;
        endcase
    end

    slr_ring u_ring (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_diff (w_diff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_seeded     <= 1'b0;
            r_count      <= '0;
            r_head_valid <= 1'b0;
            r_tail_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_reseed) begin
                        r_seeded <= 1'b1;
                        r_mj     <= seed_word(i_in.seed);
                        r_mk     <= t_word'(1);
                        r_step   <= '0;
                        r_state  <= S_SCATTER;
                    end
                end
                S_SCATTER: begin
                    if (r_step != '0) begin
                        r_mk <= sub_mod(r_mj, r_mk);
                        r_mj <= r_mk;
                    end
                    if (r_step == t_step'(TBL_LEN - 1)) begin
                        r_state <= S_ALIGN;
                    end else begin
                        r_step <= r_step + t_step'(1);
                    end
                end
                S_ALIGN: begin
                    r_step  <= '0;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    if (r_step == t_step'(MIX_STEPS - 1)) begin
                        r_state <= S_DRAW;
                    end else begin
                        r_step <= r_step + t_step'(1);
                    end
                end
                S_DRAW: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase

            if (w_push) begin
                r_count <= w_push_cnt;
            end

            if (w_pop) begin
                if (r_tail_valid) begin
                    r_head_dev   <= r_tail_dev;
                    r_head_cnt   <= r_tail_cnt;
                    r_tail_valid <= 1'b0;
                end else if (w_push) begin
                    r_head_dev <= w_push_dev;
                    r_head_cnt <= w_push_cnt;
                end else begin
                    r_head_valid <= 1'b0;
                end
            end else if (w_push) begin
                if (r_head_valid) begin
                    r_tail_dev   <= w_push_dev;
                    r_tail_cnt   <= w_push_cnt;
                    r_tail_valid <= 1'b1;
                end else begin
                    r_head_dev   <= w_push_dev;
                    r_head_cnt   <= w_push_cnt;
                    r_head_valid <= 1'b1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_tail_implies_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_valid |-> r_head_valid)
        else $error("Result queue tail is valid while its head is empty.");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !r_tail_valid)
        else $error("A result item was produced while the queue was full.");

    a_draw_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |=> (r_state == S_IDLE) && r_head_valid)
        else $error("The draw after a reseed did not leave a result item.");

    a_fast_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_reseed) |=> r_head_valid)
        else $error("A plain draw did not show a result item in the next cycle.");

    a_busy_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_seeded)
        else $error("The table is being rebuilt without the seeded flag set.");
`endif

endmodule

FILE: tb/subtractive_lagged_rng_tb.sv
// Self-checking testbench for the subtractive lagged generator: directed table, then random draws and reseeds.
module subtractive_lagged_rng_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slr_pkg::*;

    localparam logic CMD_DRAW     = 1'b0;
    localparam logic CMD_RESEED   = 1'b1;
    localparam int   RANDOM_ITEMS = 700;
    localparam int   DRAIN_CYCLES = 300;
    localparam int   RUN_LIMIT    = 1500000;
    localparam int unsigned BILLION = 32'd1000000000;

    typedef struct packed {
        logic   command;
        t_seed  seed;
        logic   count_known;
        t_count count;
    } t_row;

    typedef struct packed {
        t_word  deviate;
        t_count draw_count;
    } t_draw;

    logic i_clk = 1'b0;
    logic i_rst_n;

    slr_in_if  in_ch();
    slr_out_if out_ch();

    subtractive_lagged_rng u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_row script [0:19] = '{
        '{CMD_DRAW,   28'd0,         1'b1, 32'd1},
        '{CMD_DRAW,   28'hFFFFFFF,   1'b1, 32'd2},
        '{CMD_RESEED, 28'd0,         1'b1, 32'd1},
        '{CMD_RESEED, 28'd161803398, 1'b1, 32'd1},
        '{CMD_RESEED, 28'd161803399, 1'b1, 32'd1},
        '{CMD_RESEED, 28'hFFFFFFF,   1'b1, 32'd1},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd2},
        '{CMD_DRAW,   28'hFFFFFFF,   1'b1, 32'd3},
        '{CMD_RESEED, 28'd1,         1'b1, 32'd1},
        '{CMD_RESEED, 28'd161803397, 1'b1, 32'd1},
        '{CMD_RESEED, 28'h5555555,   1'b1, 32'd1},
        '{CMD_RESEED, 28'hAAAAAAA,   1'b1, 32'd1},
        '{CMD_DRAW,   28'h5555555,   1'b1, 32'd2},
        '{CMD_DRAW,   28'hAAAAAAA,   1'b1, 32'd3},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd4},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd5},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd6},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd7},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd8},
        '{CMD_DRAW,   28'd0,         1'b1, 32'd9}
    };

    int unsigned lag_words [1:55];
    int unsigned lead_pos;
    int unsigned trail_pos;
    bit          table_built;
    t_count      draws_since_seed;

    t_draw deviates_due [$];
    int    errors = 0;
    int    cycles = 0;
    bit    steady;

    function automatic int unsigned mod_diff(input int unsigned a, input int unsigned b);
        return (a >= b) ? (a - b) : (a + BILLION - b);
    endfunction

    function automatic int unsigned next_pos(input int unsigned p);
        return (p + 1 >= 56) ? 1 : p + 1;
    endfunction

    function automatic void rebuild_table(input t_seed seed);
        int unsigned mj;
        int unsigned mk;
        int unsigned ii;
        int unsigned clamped;
        clamped = (seed > SEED_BASE) ? 32'(SEED_BASE) : 32'(seed);
        mj = 32'(SEED_BASE) - clamped;
        lag_words[55] = mj;
        mk = 1;
        for (int i = 1; i < 55; i++) begin
            ii = (21 * i) % 55;
            lag_words[ii] = mk;
            mk = mod_diff(mj, mk);
            mj = lag_words[ii];
        end
        for (int k = 0; k < 4; k++) begin
            for (int i = 1; i <= 55; i++) begin
                lag_words[i] = mod_diff(lag_words[i], lag_words[1 + (i + 30) % 55]);
            end
        end
        lead_pos = 0;
        trail_pos = 31;
    endfunction

    function automatic t_draw predict_draw(input logic command, input t_seed seed);
        t_draw       r;
        int unsigned v;
        if (command == CMD_RESEED || !table_built) begin
            table_built = 1'b1;
            rebuild_table(seed);
            draws_since_seed = 32'd1;
        end else begin
            draws_since_seed = draws_since_seed + 32'd1;
        end
        lead_pos = next_pos(lead_pos);
        trail_pos = next_pos(trail_pos);
        v = mod_diff(lag_words[lead_pos], lag_words[trail_pos]);
        lag_words[lead_pos] = v;
        r.deviate = (v == 0) ? t_word'(1) : t_word'(v);
        r.draw_count = draws_since_seed;
        return r;
    endfunction

    function automatic int unsigned pause_len();
        int unsigned pick;
        if (steady) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 88) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer(input logic command, input t_seed seed,
                         input logic count_known, input t_count count);
        int unsigned gap;
        t_draw       want;
        gap = pause_len();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= command;
        in_ch.seed <= seed;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        want = predict_draw(command, seed);
        if (count_known) want.draw_count = count;
        deviates_due.push_back(want);
    endtask

    function automatic t_seed pick_seed();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return t_seed'($urandom_range(0, SEED_BASE));
        if (pick < 9) return t_seed'($urandom);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return SEED_BASE;
            2: return SEED_BASE + t_seed'(1);
            default: return '1;
        endcase
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_draw       want;
        int unsigned hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (deviates_due.size() == 0) begin
                    $display("%0t: unexpected item, deviate %0d draw_count %0d", $realtime,
                             out_ch.deviate, out_ch.draw_count);
                    errors++;
                end else begin
                    want = deviates_due.pop_front();
                    if (out_ch.deviate !== want.deviate) begin
                        $display("%0t: deviate expected %0d actual %0d", $realtime,
                                 want.deviate, out_ch.deviate);
                        errors++;
                    end
                    if (out_ch.draw_count !== want.draw_count) begin
                        $display("%0t: draw_count expected %0d actual %0d", $realtime,
                                 want.draw_count, out_ch.draw_count);
                        errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                out_ch.ready <= 1'b1;
                hold_left = pause_len();
            end
        end
    end

    initial begin
        logic command;
        steady = 1'b0;
        table_built = 1'b0;
        lead_pos = 0;
        trail_pos = 31;
        draws_since_seed = '0;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.command <= CMD_DRAW;
        in_ch.seed <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            offer(script[n].command, script[n].seed, script[n].count_known, script[n].count);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n % 175) < 40;
            command = ($urandom_range(0, 99) < 4) ? CMD_RESEED : CMD_DRAW;
            offer(command, pick_seed(), 1'b0, '0);
        end
        in_ch.valid <= 1'b0;
        steady = 1'b0;

        while (deviates_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/slr_pkg.sv
sv/slr_in_if.sv
sv/slr_out_if.sv
sv/slr_cell.sv
sv/slr_ring.sv
sv/subtractive_lagged_rng.sv
tb/subtractive_lagged_rng_tb.sv
